// ----- src/homogeneous_kernel_feature_map_unit_macros.svh -----
// assertion macros shared by the feature map rtl
// no dependencies; included by the modules that carry checks
`ifndef HOMOGENEOUS_KERNEL_FEATURE_MAP_UNIT_MACROS_SVH
`define HOMOGENEOUS_KERNEL_FEATURE_MAP_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define HKFM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hkfm: same-cycle check failed");
// next-cycle implication
`define HKFM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hkfm: next-cycle check failed");
`else
`define HKFM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define HKFM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/hkfm_pkg.sv -----
// constants, codes and stage record types of the feature map unit
// no dependencies; imported by every module of the block
package hkfm_pkg;

   localparam int ORDER_MAX   = 3;
   localparam int MIN_EXP     = -20;
   localparam int MAX_EXP     = 8;
   localparam int FRAC_BITS   = 52;
   localparam int WEIGHT_BITS = 16;
   localparam int EXP_BIAS    = 1023;
   localparam int NSUB_BASE   = 8;

   localparam int VALUE_W = 64;
   localparam int EXP_W   = 11;
   localparam int WORD_W  = 32;
   localparam int ORD_W   = 2;
   localparam int IDX_W   = 3;

   localparam int ELEM_MAX    = 2 * ORDER_MAX + 1;
   localparam int NSUB_MAX    = NSUB_BASE * (ORDER_MAX + 1);
   localparam int EXP_SPAN    = MAX_EXP - MIN_EXP + 1;
   localparam int TABLE_DEPTH = ELEM_MAX * NSUB_MAX * EXP_SPAN;
   localparam int TBL_AW      = $clog2(TABLE_DEPTH);
   localparam int ROW_W       = $clog2(NSUB_MAX * EXP_SPAN);
   localparam int OFF_W       = $clog2(EXP_SPAN);
   localparam int NSUB_W      = $clog2(NSUB_MAX + 1);
   localparam int PROD_W      = FRAC_BITS + NSUB_W;
   localparam int EXP_LO      = EXP_BIAS + MIN_EXP;
   localparam int EXP_HI      = EXP_BIAS + MAX_EXP;

   typedef enum logic {
      KIND_MAP   = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   typedef logic signed [WORD_W-1:0] word_type;

   // one request after row and weight are known
   typedef struct packed {
      kind_type                 kind;
      logic                     neg;
      logic                     zero;
      logic [ROW_W-1:0]         row;
      logic [WEIGHT_BITS-1:0]   weight;
      logic [IDX_W-1:0]         last_idx;
      logic [TBL_AW-1:0]        wr_addr;
      word_type                 wr_word;
   } row_item_type;

   // one feature element with its two table samples
   typedef struct packed {
      word_type                 f1;
      word_type                 f2;
      logic [WEIGHT_BITS-1:0]   weight;
      logic                     neg;
      logic                     zero;
      logic [IDX_W-1:0]         idx;
      logic                     last;
   } elem_item_type;

endpackage

// ----- src/hkfm_front.sv -----
// front end: field split, window test, fraction scaling and row number
// depends on hkfm_pkg; three register stages with valid and ready
module hkfm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hkfm_pkg::ORD_W-1:0]    order,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  hkfm_pkg::kind_type            in_kind,
   input  logic [hkfm_pkg::VALUE_W-1:0]  in_value_bits,
   input  logic [hkfm_pkg::TBL_AW-1:0]   in_addr,
   input  hkfm_pkg::word_type            in_word,
   output logic                          out_valid,
   input  logic                          out_ready,
   output hkfm_pkg::row_item_type        out_item
);
   import hkfm_pkg::*;

   logic [EXP_W-1:0]  biased;
   logic [ORD_W-1:0]  ord_eff;

   // stage 1
   logic                  s1_ready;
   logic                  s1_valid_ff;
   kind_type              s1_kind_ff;
   logic                  s1_neg_ff, s1_neg_in;
   logic                  s1_zero_ff, s1_zero_in;
   logic [OFF_W-1:0]      s1_off_ff, s1_off_in;
   logic [FRAC_BITS-1:0]  s1_frac_ff, s1_frac_in;
   logic [NSUB_W-1:0]     s1_nsub_ff, s1_nsub_in;
   logic [IDX_W-1:0]      s1_last_ff, s1_last_in;
   logic [TBL_AW-1:0]     s1_addr_ff;
   word_type              s1_word_ff;

   // stage 2
   logic                    s2_ready;
   logic                    s2_valid_ff;
   logic [PROD_W-1:0]       prod;
   kind_type                s2_kind_ff;
   logic                    s2_neg_ff, s2_zero_ff;
   logic [NSUB_W-1:0]       s2_rowoff_ff, s2_rowoff_in;
   logic [WEIGHT_BITS-1:0]  s2_weight_ff, s2_weight_in;
   logic [ROW_W-1:0]        s2_base_ff, s2_base_in;
   logic [IDX_W-1:0]        s2_last_ff;
   logic [TBL_AW-1:0]       s2_addr_ff;
   word_type                s2_word_ff;

   // stage 3
   logic          s3_ready;
   logic          s3_valid_ff;
   row_item_type  s3_item_ff, s3_item_in;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1 decode
   assign biased = in_value_bits[VALUE_W-2 -: EXP_W];

   always_comb begin
      if (order == '0) begin
         ord_eff = ORD_W'(1);
      end else if (int'(order) > ORDER_MAX) begin
         ord_eff = ORD_W'(ORDER_MAX);
      end else begin
         ord_eff = order;
      end
      s1_neg_in  = in_value_bits[VALUE_W-1];
      s1_zero_in = (in_value_bits[VALUE_W-2:0] == '0) ||
                   (biased <= EXP_W'(EXP_LO)) || (biased >= EXP_W'(EXP_HI));
      // a zeroed value keeps its row small so its dummy reads stay inside the table
      s1_off_in  = s1_zero_in ? '0 : OFF_W'(biased - EXP_W'(EXP_LO));
      s1_frac_in = in_value_bits[FRAC_BITS-1:0];
      s1_nsub_in = NSUB_W'(NSUB_BASE * (int'(ord_eff) + 1));
      s1_last_in = IDX_W'(2 * int'(ord_eff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_kind_ff <= in_kind;
         s1_neg_ff  <= s1_neg_in;
         s1_zero_ff <= s1_zero_in;
         s1_off_ff  <= s1_off_in;
         s1_frac_ff <= s1_frac_in;
         s1_nsub_ff <= s1_nsub_in;
         s1_last_ff <= s1_last_in;
         s1_addr_ff <= in_addr;
         s1_word_ff <= in_word;
      end
   end

   // stage 2: fraction times subdivisions, exponent offset times subdivisions
   assign prod         = s1_frac_ff * s1_nsub_ff;
   assign s2_rowoff_in = prod[PROD_W-1:FRAC_BITS];
   assign s2_weight_in = prod[FRAC_BITS-1 -: WEIGHT_BITS];
   assign s2_base_in   = ROW_W'(ROW_W'(s1_off_ff) * ROW_W'(s1_nsub_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_kind_ff   <= s1_kind_ff;
         s2_neg_ff    <= s1_neg_ff;
         s2_zero_ff   <= s1_zero_ff;
         s2_rowoff_ff <= s2_rowoff_in;
         s2_weight_ff <= s2_weight_in;
         s2_base_ff   <= s2_base_in;
         s2_last_ff   <= s1_last_ff;
         s2_addr_ff   <= s1_addr_ff;
         s2_word_ff   <= s1_word_ff;
      end
   end

   // stage 3: final row number
   always_comb begin
      s3_item_in.kind     = s2_kind_ff;
      s3_item_in.neg      = s2_neg_ff;
      s3_item_in.zero     = s2_zero_ff;
      s3_item_in.row      = s2_base_ff + ROW_W'(s2_rowoff_ff);
      s3_item_in.weight   = s2_weight_ff;
      s3_item_in.last_idx = s2_last_ff;
      s3_item_in.wr_addr  = s2_addr_ff;
      s3_item_in.wr_word  = s2_word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

endmodule

// ----- src/hkfm_seq.sv -----
// element sequencer and sample table: one element per cycle unless the output stalls, two reads
// depends on hkfm_pkg and the assertion macro header
`include "homogeneous_kernel_feature_map_unit_macros.svh"
module hkfm_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  hkfm_pkg::row_item_type     in_item,
   output logic                       out_valid,
   input  logic                       out_ready,
   output hkfm_pkg::elem_item_type    out_item
);
   import hkfm_pkg::*;

   logic               seq_valid_ff, seq_valid_in;
   row_item_type       seq_item_ff;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [TBL_AW-1:0]  a1_ff, a1_in;
   logic [TBL_AW-1:0]  a2_ff, a2_in;
   logic [TBL_AW-1:0]  n_load, a1_load;
   logic               done, fire, load, step, wr_en, rd_en;

   logic                    mem_ready;
   logic                    mem_valid_ff;
   word_type                sample_mem [TABLE_DEPTH];
   word_type                f1_ff, f2_ff;
   logic [WEIGHT_BITS-1:0]  mem_weight_ff;
   logic                    mem_neg_ff, mem_zero_ff, mem_last_ff;
   logic [IDX_W-1:0]        mem_idx_ff;

   assign done      = (seq_item_ff.kind == KIND_WRITE) || (j_ff == seq_item_ff.last_idx);
   assign mem_ready = !mem_valid_ff || out_ready;
   assign fire      = seq_valid_ff && mem_ready;
   assign in_ready  = !seq_valid_ff || (fire && done);
   assign load      = in_valid && in_ready;
   assign step      = fire && !done;

   // first pair of addresses: row times element count, and one row further
   assign n_load  = TBL_AW'(in_item.last_idx) + TBL_AW'(1);
   assign a1_load = TBL_AW'(TBL_AW'(in_item.row) * n_load);

   always_comb begin
      seq_valid_in = seq_valid_ff;
      if (load) begin
         seq_valid_in = 1'b1;
      end else if (fire && done) begin
         seq_valid_in = 1'b0;
      end
      if (load) begin
         j_in  = '0;
         a1_in = a1_load;
         a2_in = a1_load + n_load;
      end else begin
         j_in  = j_ff + IDX_W'(1);
         a1_in = a1_ff + TBL_AW'(1);
         a2_in = a2_ff + TBL_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_valid_ff <= 1'b0;
      end else begin
         seq_valid_ff <= seq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         seq_item_ff <= in_item;
      end
      if (load || step) begin
         j_ff  <= j_in;
         a1_ff <= a1_in;
         a2_ff <= a2_in;
      end
   end

   // sample table, writes and reads kept in request order
   assign wr_en = fire && (seq_item_ff.kind == KIND_WRITE) &&
                  (seq_item_ff.wr_addr < TBL_AW'(TABLE_DEPTH));
   assign rd_en = fire && (seq_item_ff.kind == KIND_MAP);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem[seq_item_ff.wr_addr] <= seq_item_ff.wr_word;
      end
      if (rd_en) begin
         f1_ff <= sample_mem[a1_ff];
         f2_ff <= sample_mem[a2_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_valid_ff <= 1'b0;
      end else if (mem_ready) begin
         mem_valid_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_weight_ff <= seq_item_ff.weight;
         mem_neg_ff    <= seq_item_ff.neg;
         mem_zero_ff   <= seq_item_ff.zero;
         mem_idx_ff    <= j_ff;
         mem_last_ff   <= (j_ff == seq_item_ff.last_idx);
      end
   end

   assign out_valid       = mem_valid_ff;
   assign out_item.f1     = f1_ff;
   assign out_item.f2     = f2_ff;
   assign out_item.weight = mem_weight_ff;
   assign out_item.neg    = mem_neg_ff;
   assign out_item.zero   = mem_zero_ff;
   assign out_item.idx    = mem_idx_ff;
   assign out_item.last   = mem_last_ff;

   // a non-final element keeps the request and moves on by one element
   `HKFM_ASSERT_NEXT(a_seq_advance, clock, reset, step, seq_valid_ff && (j_ff == $past(j_ff) + IDX_W'(1)))
   // the second read address is always one row past the first
   `HKFM_ASSERT_IMPLIES(a_seq_span, clock, reset, seq_valid_ff, a2_ff == a1_ff + TBL_AW'(seq_item_ff.last_idx) + TBL_AW'(1))
   // reads never leave the table
   `HKFM_ASSERT_IMPLIES(a_seq_bound, clock, reset, rd_en, a2_ff < TBL_AW'(TABLE_DEPTH))

endmodule

// ----- src/hkfm_interp.sv -----
// interpolation datapath: difference, weighting, sum, sign and saturation
// depends on hkfm_pkg; four register stages with valid and ready
module hkfm_interp (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  hkfm_pkg::elem_item_type    in_item,
   output logic                       out_valid,
   input  logic                       out_ready,
   output hkfm_pkg::word_type         out_feature,
   output logic [hkfm_pkg::IDX_W-1:0] out_idx,
   output logic                       out_last
);
   import hkfm_pkg::*;

   localparam int DIFF_W = WORD_W + 1;
   localparam int MUL_W  = DIFF_W + WEIGHT_BITS + 1;
   localparam int Q_W    = MUL_W - WEIGHT_BITS;

   // difference stage
   logic                     d_ready, d_valid_ff;
   logic signed [DIFF_W-1:0] d_diff_ff, d_diff_in;
   word_type                 d_f1_ff;
   logic [WEIGHT_BITS-1:0]   d_weight_ff;
   logic                     d_neg_ff, d_zero_ff, d_last_ff;
   logic [IDX_W-1:0]         d_idx_ff;

   // product stage
   logic                     p_ready, p_valid_ff;
   logic signed [MUL_W-1:0]  p_prod;
   logic signed [Q_W-1:0]    p_q_ff;
   word_type                 p_f1_ff;
   logic                     p_neg_ff, p_zero_ff, p_last_ff;
   logic [IDX_W-1:0]         p_idx_ff;

   // sum stage
   logic                     s_ready, s_valid_ff;
   logic signed [Q_W-1:0]    s_sum;
   word_type                 s_val_ff;
   logic                     s_neg_ff, s_zero_ff, s_last_ff;
   logic [IDX_W-1:0]         s_idx_ff;

   // output register
   logic                     o_ready, o_valid_ff;
   word_type                 o_feature_ff, o_feature_in;
   logic [IDX_W-1:0]         o_idx_ff;
   logic                     o_last_ff;

   assign o_ready  = !o_valid_ff || out_ready;
   assign s_ready  = !s_valid_ff || o_ready;
   assign p_ready  = !p_valid_ff || s_ready;
   assign d_ready  = !d_valid_ff || p_ready;
   assign in_ready = d_ready;

   assign d_diff_in = DIFF_W'(in_item.f2) - DIFF_W'(in_item.f1);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (d_ready) begin
         d_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (d_ready && in_valid) begin
         d_diff_ff   <= d_diff_in;
         d_f1_ff     <= in_item.f1;
         d_weight_ff <= in_item.weight;
         d_neg_ff    <= in_item.neg;
         d_zero_ff   <= in_item.zero;
         d_idx_ff    <= in_item.idx;
         d_last_ff   <= in_item.last;
      end
   end

   // weight is an unsigned fraction; arithmetic shift gives the floor
   assign p_prod = d_diff_ff * $signed({1'b0, d_weight_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (p_ready) begin
         p_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready && d_valid_ff) begin
         p_q_ff    <= p_prod[MUL_W-1:WEIGHT_BITS];
         p_f1_ff   <= d_f1_ff;
         p_neg_ff  <= d_neg_ff;
         p_zero_ff <= d_zero_ff;
         p_idx_ff  <= d_idx_ff;
         p_last_ff <= d_last_ff;
      end
   end

   // the sum lies between the two samples, so 32 bits hold it
   assign s_sum = Q_W'(p_f1_ff) + p_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (s_ready) begin
         s_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s_ready && p_valid_ff) begin
         s_val_ff  <= s_sum[WORD_W-1:0];
         s_neg_ff  <= p_neg_ff;
         s_zero_ff <= p_zero_ff;
         s_idx_ff  <= p_idx_ff;
         s_last_ff <= p_last_ff;
      end
   end

   // zero flag and sign, with the most negative word saturating to the largest positive one
   always_comb begin
      if (s_zero_ff) begin
         o_feature_in = '0;
      end else if (!s_neg_ff) begin
         o_feature_in = s_val_ff;
      end else if (s_val_ff == {1'b1, {(WORD_W-1){1'b0}}}) begin
         o_feature_in = {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
         o_feature_in = -s_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (o_ready) begin
         o_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (o_ready && s_valid_ff) begin
         o_feature_ff <= o_feature_in;
         o_idx_ff     <= s_idx_ff;
         o_last_ff    <= s_last_ff;
      end
   end

   assign out_valid   = o_valid_ff;
   assign out_feature = o_feature_ff;
   assign out_idx     = o_idx_ff;
   assign out_last    = o_last_ff;

endmodule

// ----- src/homogeneous_kernel_feature_map_unit.sv -----
// homogeneous kernel feature map unit: order register, front end, sequencer, datapath
// depends on hkfm_pkg, hkfm_front, hkfm_seq and hkfm_interp
//
// A map request carries one IEEE double and yields 2*order+1 responses, one
// feature element each in signed Q2.29, with its element index and a last
// flag on the final one. A table-write request stores one Q2.29 sample at
// table_address (row times element count plus element) and yields nothing;
// writes beyond the 6496-word table are dropped. The table is not cleared at
// reset: load every word a map can touch before mapping. Zero, subnormal,
// special values and exponents outside (-20, 8) give all-zero elements. The
// element sequencer issues one element per cycle while its output is not
// held, so a map request occupies it for one issue per element and a table
// write for a single issue; its two table read ports and single issue slot
// set that rate. Requests keep being taken while a response waits, until
// the pipeline is full. Write order only while no request is in flight; 0
// acts as 1.
module homogeneous_kernel_feature_map_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // order register
   input  logic                                 csr_write_enable,
   input  logic [hkfm_pkg::ORD_W-1:0]           csr_write_data,
   // requests
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_kind,
   input  logic [hkfm_pkg::VALUE_W-1:0]         req_value_bits,
   input  logic [hkfm_pkg::TBL_AW-1:0]          req_table_address,
   input  logic signed [hkfm_pkg::WORD_W-1:0]   req_table_word,
   // responses
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [hkfm_pkg::WORD_W-1:0]   rsp_feature,
   output logic [hkfm_pkg::IDX_W-1:0]           rsp_element_index,
   output logic                                 rsp_last
);
   import hkfm_pkg::*;

   logic [ORD_W-1:0]  order_ff, order_in;

   // front end to sequencer
   logic          row_valid, row_ready;
   row_item_type  row_item;

   // sequencer to datapath
   logic           elem_valid, elem_ready;
   elem_item_type  elem_item;

   // order register, sampled per request in the front end
   assign order_in = csr_write_enable ? csr_write_data : order_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORD_W'(1);
      end else begin
         order_ff <= order_in;
      end
   end

   // field split, exponent window, fraction scaling, row number
   hkfm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .order         (order_ff),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_kind       (kind_type'(req_kind)),
      .in_value_bits (req_value_bits),
      .in_addr       (req_table_address),
      .in_word       (req_table_word),
      .out_valid     (row_valid),
      .out_ready     (row_ready),
      .out_item      (row_item)
   );

   // one element a cycle while the datapath takes them, with both table samples read in parallel
   hkfm_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (row_valid),
      .in_ready  (row_ready),
      .in_item   (row_item),
      .out_valid (elem_valid),
      .out_ready (elem_ready),
      .out_item  (elem_item)
   );

   // linear interpolation, sign and saturation; ends in the response register
   hkfm_interp u_interp (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (elem_valid),
      .in_ready    (elem_ready),
      .in_item     (elem_item),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_feature (rsp_feature),
      .out_idx     (rsp_element_index),
      .out_last    (rsp_last)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the homogeneous kernel feature map unit
// depends on hkfm_pkg and homogeneous_kernel_feature_map_unit; needs no other files
module tb_top;
   import hkfm_pkg::*;

   localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 24;    // wait after draining, for a trailing write to pass the pipe
   localparam int IDLE_PCT     = 7;
   localparam int PHASE_ITERS  = 13;    // picks per random phase, table loads come on top

   // one expected feature element
   typedef struct {
      word_type               feature;
      logic [IDX_W-1:0]       idx;
      logic                   last;
   } feature_elem_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_enable = 1'b0;
   logic [ORD_W-1:0]         csr_write_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_kind = 1'b0;
   logic [VALUE_W-1:0]       req_value_bits = '0;
   logic [TBL_AW-1:0]        req_table_address = '0;
   logic signed [WORD_W-1:0] req_table_word = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_feature;
   logic [IDX_W-1:0]         rsp_element_index;
   logic                     rsp_last;

   // shadow of the sample table and of which words have been loaded
   word_type      table_shadow [TABLE_DEPTH];
   bit            loaded_mask [TABLE_DEPTH];
   logic [ORD_W-1:0] order_shadow = 2'd1;
   feature_elem_type pending_features [$];

   bit          steady_flow = 1'b0;   // no idling on either side while set
   int unsigned idle_cycles = 0;
   int unsigned mismatches = 0;
   int unsigned responses_checked = 0;
   int unsigned maps_sent = 0;
   int unsigned writes_sent = 0;

   homogeneous_kernel_feature_map_unit uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_value_bits    (req_value_bits),
      .req_table_address (req_table_address),
      .req_table_word    (req_table_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_feature       (rsp_feature),
      .rsp_element_index (rsp_element_index),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // order 0 behaves as 1, anything past the maximum as the maximum
   function automatic int effective_order(input logic [ORD_W-1:0] o);
      if (o == 0)
         return 1;
      if (o > ORDER_MAX)
         return ORDER_MAX;
      return int'(o);
   endfunction

   // split the double and find the lower table row and the 16-bit weight;
   // zero, subnormal, specials and exponents outside the window give zero_out
   function automatic void locate_row(input logic [VALUE_W-1:0] bits, input int ord,
                                      output int row, output logic [WEIGHT_BITS-1:0] weight,
                                      output bit zero_out);
      logic [63:0]      prod;
      logic [EXP_W-1:0] exp_field;
      int               nsub;
      int               expo;
      nsub      = NSUB_BASE * (ord + 1);
      exp_field = bits[62:52];
      expo      = int'(exp_field) - EXP_BIAS;
      zero_out  = (bits[62:0] == 0) || (exp_field == 0) || expo <= MIN_EXP || expo >= MAX_EXP;
      prod      = {12'b0, bits[51:0]} * 64'(nsub);
      row       = 0;
      weight    = '0;
      if (!zero_out) begin
         row    = (expo - MIN_EXP) * nsub + int'(prod >> FRAC_BITS);
         weight = prod[FRAC_BITS-1 -: WEIGHT_BITS];
      end
   endfunction

   function automatic longint read_sample(input int addr);
      if (addr >= TABLE_DEPTH)
         return 0;
      return table_shadow[addr];
   endfunction

   // push the expected elements of one accepted map request
   function automatic void predict_features(input logic [VALUE_W-1:0] bits);
      int                     ord;
      int                     n;
      int                     row;
      logic [WEIGHT_BITS-1:0] weight;
      bit                     zero_out;
      longint                 f1;
      longint                 f2;
      longint                 val;
      feature_elem_type       elem;
      ord = effective_order(order_shadow);
      n   = 2 * ord + 1;
      locate_row(bits, ord, row, weight, zero_out);
      for (int j = 0; j < n; j++) begin
         val = 0;
         if (!zero_out) begin
            f1  = read_sample(row * n + j);
            f2  = read_sample((row + 1) * n + j);
            // arithmetic shift gives the floor of the scaled difference
            val = f1 + (((f2 - f1) * longint'(weight)) >>> WEIGHT_BITS);
            if (bits[63])
               val = -val;
            if (val > 64'sd2147483647)
               val = 64'sd2147483647;
         end
         elem.feature = word_type'(val);
         elem.idx     = IDX_W'(j);
         elem.last    = (j == n - 1);
         pending_features.push_back(elem);
      end
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic word_type sample_word();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         default: return word_type'($urandom);
      endcase
   endfunction

   // offer one request and wait for the handshake; the shadow state is
   // updated in acceptance order
   task automatic send_request(input kind_type kind, input logic [VALUE_W-1:0] bits,
                               input logic [TBL_AW-1:0] addr, input word_type word);
      while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_kind          <= kind;
      req_value_bits    <= bits;
      req_table_address <= addr;
      req_table_word    <= word;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (kind == KIND_WRITE) begin
         writes_sent++;
         if (addr < TABLE_DEPTH) begin
            table_shadow[addr] = word;
            loaded_mask[addr]  = 1'b1;
         end
      end else begin
         maps_sent++;
         predict_features(bits);
      end
   endtask

   // load any still-unwritten words of the two rows the value reads, then map it
   task automatic map_value(input logic [VALUE_W-1:0] bits);
      int                     ord;
      int                     n;
      int                     row;
      int                     addr;
      logic [WEIGHT_BITS-1:0] weight;
      bit                     zero_out;
      ord = effective_order(order_shadow);
      n   = 2 * ord + 1;
      locate_row(bits, ord, row, weight, zero_out);
      if (!zero_out) begin
         // rows row and row+1 occupy 2n consecutive words
         for (int k = 0; k < 2 * n; k++) begin
            addr = row * n + k;
            if (addr < TABLE_DEPTH && !loaded_mask[addr])
               send_request(KIND_WRITE, {$urandom, $urandom}, TBL_AW'(addr), sample_word());
         end
      end
      send_request(KIND_MAP, bits, TBL_AW'($urandom), word_type'($urandom));
   endtask

   // fill the lower row with lo_word and the upper row with hi_word, then map
   task automatic map_with_rows(input logic [VALUE_W-1:0] bits, input word_type lo_word,
                                input word_type hi_word);
      int                     ord;
      int                     n;
      int                     row;
      logic [WEIGHT_BITS-1:0] weight;
      bit                     zero_out;
      ord = effective_order(order_shadow);
      n   = 2 * ord + 1;
      locate_row(bits, ord, row, weight, zero_out);
      for (int k = 0; k < 2 * n; k++)
         send_request(KIND_WRITE, {$urandom, $urandom}, TBL_AW'(row * n + k),
                      (k < n) ? lo_word : hi_word);
      send_request(KIND_MAP, bits, TBL_AW'($urandom), word_type'($urandom));
   endtask

   // stop offering requests until every expected response is back, then
   // allow for a table write still in the pipe
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_features.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_order(input logic [ORD_W-1:0] o);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= o;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      order_shadow = o;
   endtask

   function automatic logic [VALUE_W-1:0] window_value();
      return {1'($urandom), EXP_W'($urandom_range(EXP_HI - 1, EXP_LO + 1)),
              20'($urandom), 32'($urandom)};
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset order, lowest and highest exponent in the window, fraction extremes
   task automatic test_fraction_extremes();
      map_value({1'b0, EXP_W'(EXP_LO + 1), 52'h0});
      map_value({1'b1, EXP_W'(EXP_HI - 1), {52{1'b1}}});
      map_value({1'b0, EXP_W'(EXP_BIAS), 52'h8_0000_0000_0000});
      map_value(window_value());
   endtask

   // zeros, subnormal, infinities, nan and exponents on the window edges
   task automatic test_special_values();
      map_value(64'h0000_0000_0000_0000);
      map_value(64'h8000_0000_0000_0000);
      map_value(64'h000f_ffff_ffff_ffff);
      map_value(64'h7ff0_0000_0000_0000);
      map_value(64'hfff0_0000_0000_0000);
      map_value(64'h7fff_ffff_ffff_ffff);
      map_value({1'b0, EXP_W'(EXP_LO), {52{1'b1}}});
      map_value({1'b1, EXP_W'(EXP_HI), 52'h0});
   endtask

   // negated most-negative sample saturates; widest interpolation span
   task automatic test_saturation();
      map_with_rows({1'b1, EXP_W'(EXP_BIAS), 52'h0}, 32'sh8000_0000, sample_word());
      map_with_rows({1'b0, EXP_W'(EXP_BIAS), 52'h0}, 32'sh8000_0000, sample_word());
      map_with_rows({1'b0, EXP_W'(EXP_HI - 1), {52{1'b1}}}, 32'sh7fff_ffff, 32'sh8000_0000);
      map_with_rows({1'b1, EXP_W'(EXP_HI - 1), {52{1'b1}}}, 32'sh8000_0000, 32'sh7fff_ffff);
   endtask

   // order settings 0, 2 and 3, top row of the table, dropped out-of-range writes
   task automatic test_order_settings();
      logic [ORD_W-1:0] orders [3] = '{2'd0, 2'd2, 2'd3};
      foreach (orders[i]) begin
         program_order(orders[i]);
         map_value({1'b0, EXP_W'(EXP_HI - 1), {52{1'b1}}});
      end
      send_request(KIND_WRITE, {$urandom, $urandom}, TBL_AW'(TABLE_DEPTH), sample_word());
      send_request(KIND_WRITE, {$urandom, $urandom}, {TBL_AW{1'b1}}, sample_word());
   endtask

   // random phases: mostly in-window values, some noise and table traffic
   task automatic test_random_traffic();
      logic [ORD_W-1:0] phase_orders [4] = '{2'd3, 2'd1, 2'd2, 2'd0};
      int unsigned      pick;
      foreach (phase_orders[p]) begin
         program_order(phase_orders[p]);
         steady_flow = (p == 1);
         for (int i = 0; i < PHASE_ITERS; i++) begin
            // in the third phase, hold off once midway until the pipeline is empty
            if (p == 2 && i == PHASE_ITERS / 2)
               drain_responses();
            pick = $urandom_range(99);
            if (pick < 72)
               map_value(window_value());
            else if (pick < 84)
               map_value({$urandom, $urandom});
            else if (pick < 96)
               send_request(KIND_WRITE, {$urandom, $urandom},
                            TBL_AW'($urandom_range(TABLE_DEPTH - 1)), sample_word());
            else
               send_request(KIND_WRITE, {$urandom, $urandom},
                            TBL_AW'($urandom_range((1 << TBL_AW) - 1, TABLE_DEPTH)),
                            sample_word());
         end
      end
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // response side: random back-pressure and in-order checking
   // ---------------------------------------------------------------------

   always @(posedge clock)
      rsp_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin : check_responses
      feature_elem_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_features.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: feature %0d index %0d last %0d",
                        rsp_feature, rsp_element_index, rsp_last);
         end else begin
            want = pending_features.pop_front();
            responses_checked++;
            if (rsp_feature !== want.feature || rsp_element_index !== want.idx ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected feature %0d index %0d last %0d, got %0d %0d %0d",
                           want.feature, want.idx, want.last,
                           rsp_feature, rsp_element_index, rsp_last);
            end
         end
      end
   end

   // watchdog: cycles in a row with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // sequence of tests
   // ---------------------------------------------------------------------

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fraction_extremes();
      test_special_values();
      test_saturation();
      test_order_settings();
      test_random_traffic();
      drain_responses();
      $display("covered %0d map requests and %0d table writes over orders 0 to 3,",
               maps_sent, writes_sent);
      $display("with %0d responses checked and %0d mismatches", responses_checked, mismatches);
      if (mismatches == 0 && pending_features.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/hkfm_pkg.sv
src/hkfm_front.sv
src/hkfm_seq.sv
src/hkfm_interp.sv
src/homogeneous_kernel_feature_map_unit.sv
tb/tb_top.sv
